// ----- sv/grcd_pkg.sv -----
package grcd_pkg;

  localparam int MAP_BITS    = 6;
  localparam int MAP_SIDE    = 64;
  localparam int MEM_AW      = 2 * MAP_BITS;
  localparam int MEM_DEPTH   = MAP_SIDE * MAP_SIDE;
  localparam int ANG_BITS    = 10;
  localparam int ANGLE_STEPS = 1024;
  localparam int NUM_W       = ANG_BITS + 1;   // quarter-turn numerator 0..ANGLE_STEPS
  localparam int TQ_W        = 17;             // Q16 fraction 0..65536
  localparam int MAG_W       = 15;             // Q14 magnitude 0..16384
  localparam int REC_W       = 23;             // 2^22 / mag
  localparam int DELTA_W     = 24;
  localparam int POS_W       = 14;
  localparam int DIST_W      = 16;
  localparam int QDEPTH      = 2;

  localparam logic [16:0] COEF_A = 17'd102944;
  localparam logic [15:0] COEF_B = 16'd42047;
  localparam logic [12:0] COEF_C = 13'd4640;
  localparam logic [MAG_W-1:0]   UNIT_Q14  = 15'd16384;
  localparam logic [DELTA_W-1:0] DELTA_INF = 24'hFFFFFF;
  localparam logic [POS_W-1:0]   POS_LIMIT = 14'd16383;
  localparam logic [DIST_W-1:0]  DIST_LIMIT = 16'hFFFF;

  localparam int IN_W  = 72;
  localparam int OUT_W = 56;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  typedef struct packed {
    logic                  is_cast;
    logic [MEM_AW-1:0]     addr;
    logic                  in_map;
    logic [8:0]            cell_bits;   // {filled, material}
    logic [POS_W-1:0]      px;
    logic [POS_W-1:0]      py;
    logic [1:0]            rquad;
    logic [NUM_W-1:0]      rfwd;
    logic [NUM_W-1:0]      rrev;
    logic [NUM_W-1:0]      vnum;
    logic                  vpos;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_TRIG_A, ST_TRIG_B, ST_TRIG_C, ST_TRIG_D, ST_TRIG_E,
    ST_SIGN, ST_DIV, ST_INIT, ST_WALK, ST_FMUL, ST_FCLAMP, ST_FIN
  } state_e;

endpackage

// ----- sv/grcd_recip.sv -----
module grcd_recip import grcd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] div_i,
  output logic             done_o,
  output logic [REC_W-1:0] quo_o
);
  // restoring division of 2^22 by div_i, one quotient bit per cycle
  logic [MAG_W-1:0] div_q;
  logic [MAG_W-1:0] rem_q, rem_d;
  logic [REC_W-1:0] quo_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q;
  logic [MAG_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, (cnt_q == 5'(REC_W - 1))};
    ge     = rem_sh >= {1'b0, div_q};
    rem_d  = ge ? MAG_W'(rem_sh - {1'b0, div_q}) : rem_sh[MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 5'(REC_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[REC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ----- sv/grcd_fifo.sv -----
module grcd_fifo import grcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);
  cmd_t       mem_q [QDEPTH];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  assign full_o  = cnt_q == 2'(QDEPTH);
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = mem_q[rp_q];
endmodule

// ----- sv/grcd_front.sv -----
module grcd_front import grcd_pkg::*; (
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [IN_W-1:0] s_tdata_i,
  input  logic            s_tuser_i,
  input  logic            q_full_i,
  input  logic            clearing_i,
  output logic            push_o,
  output cmd_t            cmd_o
);
  logic [5:0]          cx, cy;
  logic [ANG_BITS-1:0] ray, view;
  logic [1:0]          rq, vq;
  logic [NUM_W-1:0]    rrem, vrem;

  always_comb begin
    cx   = s_tdata_i[5:0];
    cy   = s_tdata_i[11:6];
    ray  = s_tdata_i[58:49];
    view = s_tdata_i[68:59];
    // quadrant and remainder of 4*angle
    rq   = ray[ANG_BITS-1 -: 2];
    vq   = view[ANG_BITS-1 -: 2];
    rrem = NUM_W'({ray[ANG_BITS-3:0], 2'b00});
    vrem = NUM_W'({view[ANG_BITS-3:0], 2'b00});

    cmd_o.is_cast   = s_tuser_i == MODE_CAST;
    cmd_o.in_map    = ({1'b0, cx} < 7'(MAP_SIDE)) && ({1'b0, cy} < 7'(MAP_SIDE));
    cmd_o.addr      = {cy[MAP_BITS-1:0], cx[MAP_BITS-1:0]};
    cmd_o.cell_bits = {s_tdata_i[12], s_tdata_i[20:13]};
    cmd_o.px        = s_tdata_i[34:21];
    cmd_o.py        = s_tdata_i[48:35];
    cmd_o.rquad     = rq;
    cmd_o.rfwd      = rrem;
    cmd_o.rrev      = NUM_W'(ANGLE_STEPS) - rrem;
    // cosine uses the reversed fraction in quadrants 0 and 2, positive in 0 and 3
    cmd_o.vnum      = (vq == 2'd0 || vq == 2'd2) ? NUM_W'(ANGLE_STEPS) - vrem : vrem;
    cmd_o.vpos      = vq == 2'd0 || vq == 2'd3;
  end

  assign s_tready_o = !q_full_i && !clearing_i;
  assign push_o     = s_tvalid_i && s_tready_o;
endmodule

// ----- sv/grcd_back.sv -----
module grcd_back import grcd_pkg::*; #(
  parameter int MAX_STEPS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  output logic             clearing_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o
);
  localparam int CNT_W   = $clog2(MAX_STEPS + 1);
  localparam int ACC_W   = DELTA_W + CNT_W + 1;
  localparam int COORD_W = $clog2(MAX_STEPS + MAP_SIDE) + 2;
  localparam logic [1:0] JOB_FWD  = 2'd0;
  localparam logic [1:0] JOB_REV  = 2'd1;
  localparam logic [1:0] JOB_VIEW = 2'd2;

  state_e state_q, state_d;

  // control
  logic [MEM_AW-1:0] clr_q;
  logic [1:0]        job_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              p_valid_q;
  logic              out_valid_q;

  // payload
  cmd_t               cmd_q;
  logic [TQ_W-1:0]    t2_q, w_q, tsel;
  logic [13:0]        u_q;
  logic [17:0]        r_q;
  logic [MAG_W-1:0]   fwd_q, rev_q, cbm_q, qv;
  logic               dx_neg_q, dy_neg_q;
  logic [MAG_W-1:0]   dx_mag_q, dy_mag_q, dx_mag_n, dy_mag_n;
  logic [DELTA_W-1:0] sx, sy;
  logic [ACC_W-1:0]   dix_q, diy_q, dist_q, p_dist_q;
  logic signed [COORD_W-1:0] mx_q, my_q, mx_n, my_n;
  logic               p_inb_q, p_side_q, side_q;
  logic [8:0]         rdata_q;
  logic [45:0]        corr_p_q;
  logic [43:0]        offx_q, offy_q;
  logic               res_hit_q, res_side_q;
  logic [DIST_W-1:0]  res_dist_q;
  logic [POS_W-1:0]   res_hx_q, res_hy_q;
  logic [7:0]         res_mat_q;
  logic [OUT_W-1:0]   out_q;

  logic [8:0] mem_q [MEM_DEPTH];
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [8:0]        mem_wd;

  logic div_start, dvx_done, dvy_done;
  logic [REC_W-1:0] qx, qy;
  logic slot_free, hit_now, step_x, dx_pos, dy_pos, inb_n, load_out;

  // divisors taken straight from the trig results, valid in ST_SIGN
  grcd_recip u_recip_x (
    .clk_i, .rst_ni, .start_i(div_start), .div_i(dx_mag_n), .done_o(dvx_done), .quo_o(qx)
  );
  grcd_recip u_recip_y (
    .clk_i, .rst_ni, .start_i(div_start), .div_i(dy_mag_n), .done_o(dvy_done), .quo_o(qy)
  );

  always_comb begin
    dx_mag_n = cmd_q.rquad[0] ? fwd_q : rev_q;
    dy_mag_n = cmd_q.rquad[0] ? rev_q : fwd_q;
    dx_pos   = !dx_neg_q && dx_mag_q != '0;
    dy_pos   = !dy_neg_q && dy_mag_q != '0;
    sx       = (dx_mag_q == '0) ? DELTA_INF : DELTA_W'(qx);
    sy       = (dy_mag_q == '0) ? DELTA_INF : DELTA_W'(qy);
    slot_free = !out_valid_q || m_tready_i;
    hit_now  = p_valid_q && p_inb_q && rdata_q[8];
    step_x   = dix_q < diy_q;   // tie steps y
    mx_n     = step_x ? (dx_pos ? mx_q + COORD_W'(1) : mx_q - COORD_W'(1)) : mx_q;
    my_n     = step_x ? my_q : (dy_pos ? my_q + COORD_W'(1) : my_q - COORD_W'(1));
    inb_n    = !mx_n[COORD_W-1] && (mx_n < COORD_W'(MAP_SIDE)) &&
               !my_n[COORD_W-1] && (my_n < COORD_W'(MAP_SIDE));
    case (job_q)
      JOB_FWD: tsel = TQ_W'(cmd_q.rfwd) << (16 - ANG_BITS);
      JOB_REV: tsel = TQ_W'(cmd_q.rrev) << (16 - ANG_BITS);
      default: tsel = TQ_W'(cmd_q.vnum) << (16 - ANG_BITS);
    endcase
    qv = (r_q + 18'd2 > 18'(UNIT_Q14) << 2) ? UNIT_Q14 : MAG_W'((r_q + 18'd2) >> 2);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == MEM_AW'(MEM_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (q_valid_i) state_d = q_cmd_i.is_cast ? ST_TRIG_A : ST_FIN;
      ST_TRIG_A: state_d = ST_TRIG_B;
      ST_TRIG_B: state_d = ST_TRIG_C;
      ST_TRIG_C: state_d = ST_TRIG_D;
      ST_TRIG_D: state_d = ST_TRIG_E;
      ST_TRIG_E: state_d = (job_q == JOB_VIEW) ? ST_SIGN : ST_TRIG_A;
      ST_SIGN:   state_d = ST_DIV;
      ST_DIV:    if (dvx_done && dvy_done) state_d = ST_INIT;
      ST_INIT:   state_d = ST_WALK;
      ST_WALK: begin
        if (hit_now) state_d = ST_FMUL;
        else if (cnt_q == CNT_W'(MAX_STEPS)) state_d = ST_FIN;
      end
      ST_FMUL:   state_d = ST_FCLAMP;
      ST_FCLAMP: state_d = ST_FIN;
      ST_FIN:    if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o    = state_q == ST_IDLE && q_valid_i;
    clearing_o = state_q == ST_CLEAR;
    div_start  = state_q == ST_SIGN;
    load_out   = state_q == ST_FIN && slot_free;
    mem_we     = clearing_o || (q_pop_o && !q_cmd_i.is_cast && q_cmd_i.in_map);
    mem_wa     = clearing_o ? clr_q : q_cmd_i.addr;
    mem_wd     = clearing_o ? 9'd0 : q_cmd_i.cell_bits;
    mem_ra     = {my_n[MAP_BITS-1:0], mx_n[MAP_BITS-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      job_q       <= JOB_FWD;
      cnt_q       <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing_o) clr_q <= clr_q + MEM_AW'(1);
      if (q_pop_o) job_q <= JOB_FWD;
      else if (state_q == ST_TRIG_E) job_q <= job_q + 2'd1;
      if (state_q == ST_INIT) begin
        cnt_q     <= '0;
        p_valid_q <= 1'b0;
      end else if (state_q == ST_WALK && !hit_now && cnt_q != CNT_W'(MAX_STEPS)) begin
        cnt_q     <= cnt_q + CNT_W'(1);
        p_valid_q <= 1'b1;
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cmd_q      <= q_cmd_i;
        res_hit_q  <= 1'b0;
        res_dist_q <= '0;
        res_hx_q   <= '0;
        res_hy_q   <= '0;
        res_side_q <= 1'b0;
        res_mat_q  <= '0;
      end
      ST_TRIG_A: t2_q <= TQ_W'(({17'd0, tsel} * {17'd0, tsel}) >> 16);
      ST_TRIG_B: u_q  <= 14'(({17'd0, COEF_C} * {13'd0, t2_q}) >> 16);
      ST_TRIG_C: w_q  <= TQ_W'(({17'd0, 16'(COEF_B - 16'(u_q))} * {16'd0, t2_q}) >> 16);
      ST_TRIG_D: r_q  <= 18'(({17'd0, 17'(COEF_A - w_q)} * {17'd0, tsel}) >> 16);
      ST_TRIG_E: begin
        case (job_q)
          JOB_FWD: fwd_q <= qv;
          JOB_REV: rev_q <= qv;
          default: cbm_q <= qv;
        endcase
      end
      ST_SIGN: begin
        // sine: +fwd, +rev, -fwd, -rev; cosine: +rev, -fwd, -rev, +fwd
        dy_mag_q <= dy_mag_n;
        dy_neg_q <= cmd_q.rquad[1];
        dx_mag_q <= dx_mag_n;
        dx_neg_q <= cmd_q.rquad == 2'd1 || cmd_q.rquad == 2'd2;
      end
      ST_INIT: begin
        dix_q <= ACC_W'(({24'd0, (dx_pos ? 9'd256 - {1'b0, cmd_q.px[7:0]}
                                        : {1'b0, cmd_q.px[7:0]})} * {9'd0, sx}) >> 8);
        diy_q <= ACC_W'(({24'd0, (dy_pos ? 9'd256 - {1'b0, cmd_q.py[7:0]}
                                        : {1'b0, cmd_q.py[7:0]})} * {9'd0, sy}) >> 8);
        mx_q  <= COORD_W'(cmd_q.px[POS_W-1:8]);
        my_q  <= COORD_W'(cmd_q.py[POS_W-1:8]);
      end
      ST_WALK: begin
        if (hit_now) begin
          dist_q     <= p_dist_q;
          side_q     <= p_side_q;
          res_mat_q  <= rdata_q[7:0];
        end else begin
          // step and fetch the new cell; tested next cycle
          mx_q     <= mx_n;
          my_q     <= my_n;
          p_inb_q  <= inb_n;
          p_side_q <= !step_x;
          p_dist_q <= step_x ? dix_q : diy_q;
          if (step_x) dix_q <= dix_q + ACC_W'(sx);
          else        diy_q <= diy_q + ACC_W'(sy);
        end
      end
      ST_FMUL: begin
        // clipping keeps the products narrow; results saturate the same way
        corr_p_q <= {15'd0, (40'(dist_q) > 40'h40000000) ? 31'h40000000 : 31'(dist_q)} *
                    {31'd0, cbm_q};
        offx_q   <= {15'd0, (40'(dist_q) > 40'h10000000) ? 29'h10000000 : 29'(dist_q)} *
                    {29'd0, dx_mag_q};
        offy_q   <= {15'd0, (40'(dist_q) > 40'h10000000) ? 29'h10000000 : 29'(dist_q)} *
                    {29'd0, dy_mag_q};
      end
      ST_FCLAMP: begin
        res_hit_q  <= 1'b1;
        res_side_q <= side_q;
        if (!cmd_q.vpos || cbm_q == '0)          res_dist_q <= '0;
        else if ((corr_p_q >> 14) > 46'(DIST_LIMIT)) res_dist_q <= DIST_LIMIT;
        else                                     res_dist_q <= DIST_W'(corr_p_q >> 14);
        if (dx_neg_q)
          res_hx_q <= ((offx_q >> 14) > 44'(cmd_q.px)) ? '0 : POS_W'(44'(cmd_q.px) - (offx_q >> 14));
        else
          res_hx_q <= ((offx_q >> 14) + 44'(cmd_q.px) > 44'(POS_LIMIT)) ? POS_LIMIT
                      : POS_W'(44'(cmd_q.px) + (offx_q >> 14));
        if (dy_neg_q)
          res_hy_q <= ((offy_q >> 14) > 44'(cmd_q.py)) ? '0 : POS_W'(44'(cmd_q.py) - (offy_q >> 14));
        else
          res_hy_q <= ((offy_q >> 14) + 44'(cmd_q.py) > 44'(POS_LIMIT)) ? POS_LIMIT
                      : POS_W'(44'(cmd_q.py) + (offy_q >> 14));
      end
      default: ;
    endcase
    if (load_out)
      out_q <= {2'b00, res_mat_q, res_side_q, res_hy_q, res_hx_q, res_dist_q, res_hit_q};
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !q_pop_o) else $error("queue popped during clear pass");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_STEPS)) else $error("step count past limit");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !(out_valid_q && !m_tready_i)) else $error("result overwritten");
  a_walk_needs_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INIT |-> dvx_done && dvy_done) else $error("walk before reciprocal");
endmodule

// ----- sv/grid_ray_caster_dda_core.sv -----
// Grid ray caster: keeps a 64x64 cell map and walks rays through it by DDA.
// Input channel s_axis: tuser = mode (0 writes a cell, 1 casts a ray), tdata
// carries the cell or ray fields. Every item yields exactly one result item on
// m_axis, in order; a write returns an all-zero result.
// A front decoder splits angles into quadrants and pushes a command into a
// two-entry queue; the back sequencer executes commands one at a time.
// Cast steps, in order: pop, trig steps ST_TRIG_A to ST_TRIG_E for each of
// three angles, sign, bit-serial reciprocal, init, then the DDA walk, which
// tests each fetched cell before stepping on, then correction and clamping
// and the output load. A hit ends the walk at the first solid cell in the map,
// a miss once MAX_STEPS steps are taken. A write updates the map when it is
// popped and goes straight to the output load. The next item is popped
// only after the output is loaded, so the walk length sets the item spacing.
// After reset a pass clears the map, one entry per cycle; s_axis_tready stays
// low until it finishes. If m_axis stalls, the finished result sits in the
// output register, the back completes the next item and waits with it, and
// the queue absorbs up to two more items before tready drops.
module grid_ray_caster_dda_core import grcd_pkg::*; #(
  parameter int MAX_STEPS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // cell_x, cell_y, cell_filled, cell_material, pos_x, pos_y, ray_angle,
  // view_offset, zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  // mode
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // hit, distance, hit_x, hit_y, hit_side, material, zero pad
  output logic [OUT_W-1:0] m_axis_tdata
);
  cmd_t push_cmd, pop_cmd;
  logic push, q_full, q_valid, q_pop, clearing;

  grcd_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  grcd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  grcd_back #(.MAX_STEPS(MAX_STEPS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i  (q_valid),
    .q_cmd_i    (pop_cmd),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );
endmodule

// ----- bench/testbench.sv -----
module testbench;
  import grcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WALK_LIMIT  = 64;
  localparam int STALL_LIMIT = 20000;

  // Input item fields; all but mode are packed into tdata from the lowest bit up.
  typedef struct {
    logic             mode;
    logic [5:0]       cell_x;
    logic [5:0]       cell_y;
    logic             cell_filled;
    logic [7:0]       cell_material;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [9:0]       ray_angle;
    logic [9:0]       view_offset;
  } ray_item_t;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic [POS_W-1:0]  hit_x;
    logic [POS_W-1:0]  hit_y;
    logic              hit_side;
    logic [7:0]        material;
  } ray_hit_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic            s_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  grid_ray_caster_dda_core DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the cell map: {filled, material}.
  logic [8:0]  shadow_map [MEM_DEPTH];
  ray_item_t   pending_items[$];
  ray_hit_t    expected_hits[$];
  int          error_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;
  int          quiet_cycles;

  // ---------------- predictor ----------------
  function automatic longint quarter_sine(int num);
    longint t, t2, u, v, w, x, r, q;
    t  = (longint'(num) << 16) / ANGLE_STEPS;
    t2 = (t * t) >> 16;
    u  = (4640 * t2) >> 16;
    v  = 42047 - u;
    w  = (v * t2) >> 16;
    x  = 102944 - w;
    r  = (x * t) >> 16;
    q  = (r + 2) >> 2;
    if (q > 16384) q = 16384;
    return q;
  endfunction

  function automatic longint trig_q14(int angle, bit want_cos);
    int a, quad, rem;
    longint fwd, rev;
    a    = angle % ANGLE_STEPS;
    quad = (a * 4) / ANGLE_STEPS;
    rem  = (a * 4) % ANGLE_STEPS;
    fwd  = quarter_sine(rem);
    rev  = quarter_sine(ANGLE_STEPS - rem);
    if (!want_cos) begin
      case (quad)
        0: return fwd;
        1: return rev;
        2: return -fwd;
        default: return -rev;
      endcase
    end
    case (quad)
      0: return rev;
      1: return -fwd;
      2: return -rev;
      default: return fwd;
    endcase
  endfunction

  function automatic longint delta_step(longint d);
    longint mag;
    mag = (d < 0) ? -d : d;
    if (mag == 0) return 64'hFFFFFF;
    return (64'd1 << 22) / mag;
  endfunction

  function automatic longint clamp_coord(longint pos, longint d, longint ray_dist);
    longint p;
    p = pos + (d * ray_dist) / 16384;   // truncates toward zero like C
    if (p < 0) p = 0;
    if (p > 16383) p = 16383;
    return p;
  endfunction

  // Applies one item to the shadow map, or walks the ray through it.
  function automatic ray_hit_t cast_or_store(ray_item_t it);
    ray_hit_t res;
    longint dx, dy, sx, sy, dix, diy, ray_dist, corr, cb, px, py;
    int stx, sty, mx, my;
    bit side;
    logic [8:0] c;
    res = '{default: '0};
    if (it.mode == MODE_WRITE) begin
      shadow_map[{it.cell_y, it.cell_x}] = {it.cell_filled, it.cell_material};
      return res;
    end
    px  = it.pos_x;
    py  = it.pos_y;
    dx  = trig_q14(it.ray_angle, 1'b1);
    dy  = trig_q14(it.ray_angle, 1'b0);
    sx  = delta_step(dx);
    sy  = delta_step(dy);
    stx = dx > 0 ? 1 : -1;
    sty = dy > 0 ? 1 : -1;
    mx  = int'(px >> 8);
    my  = int'(py >> 8);
    dix = ((dx > 0 ? longint'(mx + 1) * 256 - px : px - longint'(mx) * 256) * sx) >> 8;
    diy = ((dy > 0 ? longint'(my + 1) * 256 - py : py - longint'(my) * 256) * sy) >> 8;
    side = 1'b0;
    for (int i = 0; i < WALK_LIMIT; i++) begin
      if (dix < diy) begin
        mx += stx; dix += sx; side = 1'b0;
      end else begin
        my += sty; diy += sy; side = 1'b1;
      end
      if (mx >= 0 && my >= 0 && mx < MAP_SIDE && my < MAP_SIDE) begin
        c = shadow_map[my * MAP_SIDE + mx];
        if (c[8]) begin
          ray_dist = side ? diy - sy : dix - sx;
          cb   = trig_q14(it.view_offset, 1'b1);
          corr = 0;
          if (cb > 0) begin
            corr = (ray_dist * cb) >> 14;
            if (corr > 65535) corr = 65535;
          end
          res.hit      = 1'b1;
          res.distance = corr[15:0];
          res.hit_x    = POS_W'(clamp_coord(px, dx, ray_dist));
          res.hit_y    = POS_W'(clamp_coord(py, dy, ray_dist));
          res.hit_side = side;
          res.material = c[7:0];
          return res;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // ---------------- driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    ray_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      // Previous item (if any) was accepted this edge; predict it now.
      if (s_axis_tvalid)
        expected_hits.push_back(cast_or_store(pending_items.pop_front()));
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.mode;
        s_axis_tdata  <= {{(IN_W - 69){1'b0}}, nxt.view_offset, nxt.ray_angle, nxt.pos_y,
                          nxt.pos_x, nxt.cell_material, nxt.cell_filled, nxt.cell_y,
                          nxt.cell_x};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- receiver and monitor ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    ray_hit_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_hits.pop_front();
          if (m_axis_tdata[0] !== want.hit)
            report_mismatch("hit", m_axis_tdata[0], want.hit);
          if (m_axis_tdata[16:1] !== want.distance)
            report_mismatch("distance", m_axis_tdata[16:1], want.distance);
          if (m_axis_tdata[30:17] !== want.hit_x)
            report_mismatch("hit_x", m_axis_tdata[30:17], want.hit_x);
          if (m_axis_tdata[44:31] !== want.hit_y)
            report_mismatch("hit_y", m_axis_tdata[44:31], want.hit_y);
          if (m_axis_tdata[45] !== want.hit_side)
            report_mismatch("hit_side", m_axis_tdata[45], want.hit_side);
          if (m_axis_tdata[53:46] !== want.material)
            report_mismatch("material", m_axis_tdata[53:46], want.material);
        end
      end
      // Long hold-off lets the command queue fill and back-pressure the input.
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        m_axis_tready   <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: cycles with no handshake on either side. Covers the clear pass.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic ray_item_t cell_write(int x, int y, bit filled, int mat);
    ray_item_t it;
    it = '{default: '0};
    it.mode          = MODE_WRITE;
    it.cell_x        = 6'(x);
    it.cell_y        = 6'(y);
    it.cell_filled   = filled;
    it.cell_material = 8'(mat);
    it.pos_x         = POS_W'($urandom);  // unused bits still toggle
    it.pos_y         = POS_W'($urandom);
    return it;
  endfunction

  function automatic ray_item_t ray_cast(int px, int py, int ang, int view);
    ray_item_t it;
    it = '{default: '0};
    it.mode          = MODE_CAST;
    it.pos_x         = POS_W'(px);
    it.pos_y         = POS_W'(py);
    it.ray_angle     = 10'(ang);
    it.view_offset   = 10'(view);
    it.cell_x        = 6'($urandom);
    it.cell_y        = 6'($urandom);
    it.cell_filled   = 1'($urandom);
    it.cell_material = 8'($urandom);
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_hits.size() > 0)
      @(posedge clk_i);
  endtask

  // Random cell writes mixed with casts, mostly from inside the map border.
  task automatic random_phase(int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1: pending_items.push_back(cell_write($urandom_range(63), $urandom_range(63),
                                                 $urandom_range(1), $urandom));
        2: pending_items.push_back(ray_cast($urandom, $urandom, $urandom, $urandom));
        default: pending_items.push_back(ray_cast($urandom_range(256, 16127),
                                                  $urandom_range(256, 16127),
                                                  $urandom, $urandom_range(0, 1023)));
      endcase
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    error_count     = 0;
    send_idle_pct   = 7;
    recv_idle_pct   = 65;
    hold_off_cycles = 0;
    quiet_cycles    = 0;
    foreach (shadow_map[i]) shadow_map[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: cast on the empty map (miss), box walls, extremes, ties, axes.
    pending_items.push_back(ray_cast(16383, 16383, 1023, 1023));
    for (int i = 0; i < 64; i += 9) begin
      pending_items.push_back(cell_write(i, 0, 1, 8'h11));
      pending_items.push_back(cell_write(63, i, 1, 8'hFF));
    end
    pending_items.push_back(cell_write(0, 63, 1, 8'h00));
    pending_items.push_back(cell_write(20, 20, 1, 8'hA5));
    pending_items.push_back(cell_write(22, 20, 1, 8'h5A));
    pending_items.push_back(ray_cast(20 * 256 + 128, 128, 768, 0));   // straight -y
    pending_items.push_back(ray_cast(128, 128, 0, 0));               // straight +x, start cell solid
    pending_items.push_back(ray_cast(21 * 256, 20 * 256, 512, 256)); // -x, cos zero
    pending_items.push_back(ray_cast(21 * 256, 20 * 256, 0, 512));   // +x, negative cos
    pending_items.push_back(ray_cast(19 * 256, 19 * 256, 128, 900)); // diagonal tie
    pending_items.push_back(ray_cast(0, 0, 256, 0));                 // +y from origin
    pending_items.push_back(ray_cast(16383, 0, 640, 100));
    pending_items.push_back(cell_write(20, 20, 0, 0));               // clear again
    pending_items.push_back(ray_cast(20 * 256 + 128, 128, 768, 0));
    wait_drained();

    random_phase(150);
    wait_drained();
    send_idle_pct = 65;
    recv_idle_pct = 7;
    random_phase(150);
    // Hold the receiver off while the sender keeps offering items.
    hold_off_cycles = 600;
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(150);
    wait_drained();
    repeat (200) @(posedge clk_i);

    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
